>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/hbr_pkg.sv
// ---------------------------------------------------------------------------
// hbr_pkg
// Types and constants for the byte-range header parser.
// ---------------------------------------------------------------------------
package hbr_pkg;

    localparam int OFFSET_WIDTH_DEF = 48;
    localparam int RANGE_WIDTH      = 48;

    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_SHIFT = 8'h20;

    localparam logic [2:0] PREFIX_LEN  = 3'd6;
    localparam logic [2:0] PREFIX_LAST = 3'd5;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_mark;
    } byte_t;

    typedef struct packed {
        logic                   range_valid;
        logic [RANGE_WIDTH-1:0] range_first;
        logic                   first_present;
        logic [RANGE_WIDTH-1:0] range_last;
        logic                   last_present;
        logic                   done_res;
        logic                   status;
    } res_t;

    // Lower-case "bytes=" prefix, one character per index.
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h62;
            3'd1:    c = 8'h79;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h65;
            3'd4:    c = 8'h73;
            default: c = 8'h3D;
        endcase
        return c;
    endfunction

endpackage

>>> src/http_byte_range_parser.sv
// ---------------------------------------------------------------------------
// http_byte_range_parser
// Streaming parser for the value of an HTTP Range header.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (byte_valid/byte_ready/byte_data) carries one header byte
//   per request, then a request with end_mark set that closes the header.
//   Result channel (res_valid/res_ready/res_data) carries one result per
//   completed range (closed by a comma) and one done result per end marker,
//   which also carries the final range if the header ended on one.
// Timing: an accepted request is held in the request register; any result
//   it makes is loaded into the result register when the request advances.
// Throughput: one request per cycle while no held result stalls it. The
//   per-byte work is a character compare plus one multiply-by-ten
//   accumulate, between the request register and the result register.
// Reset: clears the request and result valid flags and returns the parser to
//   prefix matching with cleared accumulators.
// Stall: a held result blocks only a request that makes another result;
//   requests that make no result keep flowing behind it.
// ---------------------------------------------------------------------------
module http_byte_range_parser #(
    parameter int OFFSET_WIDTH = hbr_pkg::OFFSET_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          byte_valid,
    output logic          byte_ready,
    input  hbr_pkg::byte_t byte_data,
    output logic          res_valid,
    input  logic          res_ready,
    output hbr_pkg::res_t res_data
);

    localparam int AW = OFFSET_WIDTH + 4;
    localparam int RW = hbr_pkg::RANGE_WIDTH;

    // Parser phase codes
    localparam logic [2:0] PH_PREFIX     = 3'd0;
    localparam logic [2:0] PH_START      = 3'd1;
    localparam logic [2:0] PH_TAIL       = 3'd2;
    localparam logic [2:0] PH_FIRST      = 3'd3;
    localparam logic [2:0] PH_TESTSECOND = 3'd4;
    localparam logic [2:0] PH_SECOND     = 3'd5;
    localparam logic [2:0] PH_ERROR      = 3'd6;

    // Request register
    logic           item_vld_reg;
    hbr_pkg::byte_t item_reg;

    // Parser state
    logic [2:0]              phase_reg, phase_next;
    logic [2:0]              pc_reg, pc_next;
    logic [OFFSET_WIDTH-1:0] first_acc_reg, first_acc_next;
    logic [OFFSET_WIDTH-1:0] last_acc_reg, last_acc_next;
    logic                    first_seen_reg, first_seen_next;
    logic                    last_seen_reg, last_seen_next;

    // Result register
    logic          res_vld_reg, res_vld_next;
    hbr_pkg::res_t res_reg, res_next;

    logic                    emit;
    logic                    advance;
    logic [7:0]              ch;
    logic [7:0]              lc;
    logic [2:0]              idx;
    logic                    is_digit;
    logic [OFFSET_WIDTH-1:0] acc_src;
    logic [AW-1:0]           acc_ext;
    logic [AW-1:0]           prod;
    logic                    ovf;
    logic [OFFSET_WIDTH-1:0] acc_new;

    assign ch       = item_reg.ch;
    assign is_digit = (ch >= hbr_pkg::CH_ZERO) && (ch <= hbr_pkg::CH_NINE);
    assign lc       = ((ch >= hbr_pkg::CH_UPPER_A) && (ch <= hbr_pkg::CH_UPPER_Z))
                      ? ch + hbr_pkg::CASE_SHIFT : ch;
    assign idx      = (pc_reg < hbr_pkg::PREFIX_LEN) ? pc_reg : hbr_pkg::PREFIX_LAST;

    // Shared accumulate unit: acc*10 + digit, overflow when it leaves the field.
    // A fresh offset starts from zero.
    always_comb
    begin
        if (phase_reg == PH_FIRST)
        begin
            acc_src = first_acc_reg;
        end
        else if (phase_reg == PH_SECOND)
        begin
            acc_src = last_acc_reg;
        end
        else
        begin
            acc_src = '0;
        end
    end

    assign acc_ext = AW'(acc_src);
    assign prod    = (acc_ext << 3) + (acc_ext << 1) + AW'(ch[3:0]);
    assign ovf     = |prod[AW-1:OFFSET_WIDTH];
    // On overflow the accumulator keeps its old value.
    assign acc_new = ovf ? acc_src : prod[OFFSET_WIDTH-1:0];

    // Parser next state and result
    always_comb
    begin
        phase_next      = phase_reg;
        pc_next         = pc_reg;
        first_acc_next  = first_acc_reg;
        last_acc_next   = last_acc_reg;
        first_seen_next = first_seen_reg;
        last_seen_next  = last_seen_reg;
        emit            = 1'b0;

        // Range fields as the current state shows them
        res_next               = '0;
        res_next.first_present = first_seen_reg;
        res_next.range_first   = first_seen_reg ? RW'(first_acc_reg) : '0;
        res_next.last_present  = last_seen_reg;
        res_next.range_last    = last_seen_reg ? RW'(last_acc_reg) : '0;
        res_next.range_valid   = 1'b1;

        if (item_reg.end_mark)
        begin
            // Close the header: report status, emit a pending range, rearm.
            emit = 1'b1;
            res_next.done_res = 1'b1;
            if ((phase_reg == PH_TESTSECOND) || (phase_reg == PH_SECOND))
            begin
                res_next.status = 1'b0;
            end
            else
            begin
                res_next.range_valid   = 1'b0;
                res_next.range_first   = '0;
                res_next.first_present = 1'b0;
                res_next.range_last    = '0;
                res_next.last_present  = 1'b0;
                res_next.status        = 1'b1;
            end
            phase_next      = PH_PREFIX;
            pc_next         = '0;
            first_acc_next  = '0;
            last_acc_next   = '0;
            first_seen_next = 1'b0;
            last_seen_next  = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                PH_PREFIX:
                begin
                    if (lc != hbr_pkg::prefix_char(idx))
                    begin
                        phase_next = PH_ERROR;
                    end
                    else if (idx == hbr_pkg::PREFIX_LAST)
                    begin
                        pc_next    = '0;
                        phase_next = PH_START;
                    end
                    else
                    begin
                        pc_next = idx + 3'd1;
                    end
                end
                PH_START:
                begin
                    first_acc_next  = '0;
                    last_acc_next   = '0;
                    first_seen_next = 1'b0;
                    last_seen_next  = 1'b0;
                    if (ch == hbr_pkg::CH_DASH)
                    begin
                        phase_next = PH_TAIL;
                    end
                    else if (is_digit)
                    begin
                        first_seen_next = 1'b1;
                        first_acc_next  = acc_new;
                        phase_next      = ovf ? PH_ERROR : PH_FIRST;
                    end
                    else
                    begin
                        phase_next = PH_ERROR;
                    end
                end
                PH_TAIL:
                begin
                    if (is_digit)
                    begin
                        last_seen_next = 1'b1;
                        last_acc_next  = acc_new;
                        phase_next     = ovf ? PH_ERROR : PH_SECOND;
                    end
                    else
                    begin
                        phase_next = PH_ERROR;
                    end
                end
                PH_FIRST:
                begin
                    if (ch == hbr_pkg::CH_DASH)
                    begin
                        phase_next = PH_TESTSECOND;
                    end
                    else if (is_digit)
                    begin
                        first_acc_next = acc_new;
                        phase_next     = ovf ? PH_ERROR : PH_FIRST;
                    end
                    else
                    begin
                        phase_next = PH_ERROR;
                    end
                end
                PH_TESTSECOND, PH_SECOND:
                begin
                    if (ch == hbr_pkg::CH_COMMA)
                    begin
                        emit       = 1'b1;
                        phase_next = PH_START;
                    end
                    else if (is_digit)
                    begin
                        last_seen_next = 1'b1;
                        last_acc_next  = acc_new;
                        phase_next     = ovf ? PH_ERROR : PH_SECOND;
                    end
                    else
                    begin
                        phase_next = PH_ERROR;
                    end
                end
                default:
                begin
                    // Latched error, and any unused code: drop bytes until the end.
                    phase_next = PH_ERROR;
                end
            endcase
        end
    end

    // Advance unless this request makes a result and the result register is full.
    assign advance    = item_vld_reg && (!emit || !res_vld_reg || res_ready);
    assign byte_ready = !item_vld_reg || advance;

    always_comb
    begin
        if (advance && emit)
        begin
            res_vld_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_vld_next = 1'b0;
        end
        else
        begin
            res_vld_next = res_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg   <= 1'b0;
            res_vld_reg    <= 1'b0;
            phase_reg      <= PH_PREFIX;
            pc_reg         <= '0;
            first_acc_reg  <= '0;
            last_acc_reg   <= '0;
            first_seen_reg <= 1'b0;
            last_seen_reg  <= 1'b0;
        end
        else
        begin
            res_vld_reg <= res_vld_next;
            if (byte_ready)
            begin
                item_vld_reg <= byte_valid;
            end
            if (advance)
            begin
                phase_reg      <= phase_next;
                pc_reg         <= pc_next;
                first_acc_reg  <= first_acc_next;
                last_acc_reg   <= last_acc_next;
                first_seen_reg <= first_seen_next;
                last_seen_reg  <= last_seen_next;
            end
        end
    end

    // Payload registers: load on accept, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            item_reg <= byte_data;
        end
        if (advance && emit)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_vld_reg;
    assign res_data  = res_reg;

endmodule

>>> src/hbr_checker.sv
// ---------------------------------------------------------------------------
// hbr_checker
// Port-level checks for the byte-range header parser.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hbr_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           byte_valid,
    input logic           byte_ready,
    input hbr_pkg::byte_t byte_data,
    input logic           res_valid,
    input logic           res_ready,
    input hbr_pkg::res_t  res_data
);

    // Hold a stalled request.
    `ASSERT_NEXT(a_req_hold, clk, rst_n, byte_valid && !byte_ready,
                 byte_valid && $stable(byte_data), "request changed while stalled")

    // Hold a stalled result.
    `ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready,
                 res_valid && $stable(res_data), "result changed while stalled")

    // A result without a done flag is a clean range.
    `ASSERT_SAME(a_mid_range, clk, rst_n, res_valid && !res_data.done_res,
                 res_data.range_valid && !res_data.status, "stray non-range result")

    // A result without a range carries zero range fields.
    `ASSERT_SAME(a_empty_fields, clk, rst_n, res_valid && !res_data.range_valid,
                 !res_data.first_present && !res_data.last_present &&
                 (res_data.range_first == '0) && (res_data.range_last == '0),
                 "range fields set on a result without a range")

    // A range has at least one offset, and an absent offset reads as zero.
    `ASSERT_SAME(a_range_shape, clk, rst_n, res_valid && res_data.range_valid,
                 (res_data.first_present || res_data.last_present) &&
                 (res_data.first_present || (res_data.range_first == '0)) &&
                 (res_data.last_present || (res_data.range_last == '0)),
                 "malformed range result")

endmodule

bind http_byte_range_parser hbr_checker u_hbr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_data   (res_data)
);

>>> tb/tb_http_byte_range_parser.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_http_byte_range_parser
// Self-checking bench for the Range header parser: directed headers cover the
// prefix, every spec form, offset limits and malformed input. Random headers
// follow, mostly well formed with some corrupted. A byte-level parser model
// predicts every result, and a monitor compares results field by field, in
// order, under random backpressure.
// ---------------------------------------------------------------------------
module tb_http_byte_range_parser;

    localparam int          CLK_PERIOD   = 20;
    localparam int          RESET_CYCLES = 12;
    localparam int          MAX_REPORTS  = 10;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          RANDOM_ITEMS = 1000;
    localparam int          ITEM_TARGET  = 1300;
    localparam longint      TIMEOUT_NS   = 64'd10_000_000;
    localparam logic [63:0] OFFSET_MAX   = (64'd1 << hbr_pkg::OFFSET_WIDTH_DEF) - 64'd1;
    localparam logic [47:0] PREFIX_TEXT  = "bytes=";

    // Parse phases of the model, one per position inside a spec.
    typedef enum logic [2:0] {
        ST_PREFIX,
        ST_SPEC_START,
        ST_SUFFIX_DASH,
        ST_FIRST_NUM,
        ST_AFTER_DASH,
        ST_LAST_NUM,
        ST_BAD
    } parse_phase_e;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           byte_valid;
    logic           byte_ready;
    hbr_pkg::byte_t byte_data;
    logic           res_valid;
    logic           res_ready = 1'b0;
    hbr_pkg::res_t  res_data;

    http_byte_range_parser dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // -----------------------------------------------------------------------
    // Parser model: state of the header being parsed
    // -----------------------------------------------------------------------
    parse_phase_e ph;
    int unsigned  pfx_cnt;
    logic [63:0]  first_val;
    logic [63:0]  last_val;
    logic         has_first;
    logic         has_last;

    hbr_pkg::res_t expected_ranges[$];
    logic [7:0]    hdr_bytes[$];
    int            mismatches = 0;
    int            live_items = 0;
    bit            idle_on = 1'b0;
    int unsigned   rx_stall = 0;

    function automatic void clear_parse_state();
        ph        = ST_PREFIX;
        pfx_cnt   = 0;
        first_val = '0;
        last_val  = '0;
        has_first = 1'b0;
        has_last  = 1'b0;
    endfunction

    function automatic bit is_dec(input logic [7:0] c);
        return c >= hbr_pkg::CH_ZERO && c <= hbr_pkg::CH_NINE;
    endfunction

    // Append one decimal digit; drop to the error phase if the offset no
    // longer fits in OFFSET_WIDTH bits, keeping the old value.
    function automatic logic [63:0] add_digit(input logic [63:0] acc, input logic [7:0] c);
        logic [63:0] d;
        d = {56'd0, c - hbr_pkg::CH_ZERO};
        if (acc > (OFFSET_MAX - d) / 64'd10) begin
            ph = ST_BAD;
            return acc;
        end
        return acc * 64'd10 + d;
    endfunction

    function automatic hbr_pkg::res_t range_result();
        hbr_pkg::res_t r;
        r               = '0;
        r.range_valid   = 1'b1;
        r.range_first   = has_first ? first_val[hbr_pkg::RANGE_WIDTH-1:0] : '0;
        r.first_present = has_first;
        r.range_last    = has_last ? last_val[hbr_pkg::RANGE_WIDTH-1:0] : '0;
        r.last_present  = has_last;
        return r;
    endfunction

    // Advance the model by one request; return 1 when it yields a result.
    function automatic bit predict_range(input hbr_pkg::byte_t b, output hbr_pkg::res_t r);
        logic [7:0] c;
        logic [7:0] lc;
        bit         ok;
        r = '0;
        c = b.ch;
        if (b.end_mark) begin
            // End of header: only a completed spec counts as success.
            ok = (ph == ST_AFTER_DASH || ph == ST_LAST_NUM);
            if (ok)
                r = range_result();
            r.done_res = 1'b1;
            r.status   = !ok;
            clear_parse_state();
            return 1'b1;
        end
        case (ph)
            ST_PREFIX:
            begin
                lc = (c >= hbr_pkg::CH_UPPER_A && c <= hbr_pkg::CH_UPPER_Z)
                     ? c + hbr_pkg::CASE_SHIFT : c;
                if (lc != PREFIX_TEXT[8*(5-pfx_cnt) +: 8])
                    ph = ST_BAD;
                else if (pfx_cnt == 5)
                begin
                    pfx_cnt = 0;
                    ph      = ST_SPEC_START;
                end
                else
                    pfx_cnt++;
            end
            ST_SPEC_START:
            begin
                first_val = '0;
                last_val  = '0;
                has_first = 1'b0;
                has_last  = 1'b0;
                if (c == hbr_pkg::CH_DASH)
                    ph = ST_SUFFIX_DASH;
                else if (is_dec(c))
                begin
                    has_first = 1'b1;
                    ph        = ST_FIRST_NUM;
                    first_val = add_digit('0, c);
                end
                else
                    ph = ST_BAD;
            end
            ST_SUFFIX_DASH:
            begin
                if (is_dec(c))
                begin
                    has_last = 1'b1;
                    ph       = ST_LAST_NUM;
                    last_val = add_digit('0, c);
                end
                else
                    ph = ST_BAD;
            end
            ST_FIRST_NUM:
            begin
                if (c == hbr_pkg::CH_DASH)
                    ph = ST_AFTER_DASH;
                else if (is_dec(c))
                    first_val = add_digit(first_val, c);
                else
                    ph = ST_BAD;
            end
            ST_AFTER_DASH, ST_LAST_NUM:
            begin
                if (c == hbr_pkg::CH_COMMA)
                begin
                    // A comma closes the spec and emits it right away.
                    r  = range_result();
                    ph = ST_SPEC_START;
                    return 1'b1;
                end
                if (is_dec(c))
                begin
                    if (ph == ST_AFTER_DASH)
                    begin
                        has_last = 1'b1;
                        ph       = ST_LAST_NUM;
                        last_val = add_digit('0, c);
                    end
                    else
                        last_val = add_digit(last_val, c);
                end
                else
                    ph = ST_BAD;
            end
            default:
                ph = ST_BAD;   // latched error: ignore bytes until the end marker
        endcase
        return 1'b0;
    endfunction

    // -----------------------------------------------------------------------
    // Result monitor: compare each accepted result with the oldest prediction
    // -----------------------------------------------------------------------
    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
    endtask

    always @(posedge clk)
    begin
        hbr_pkg::res_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_ranges.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result %h with none expected", $time, res_data);
            end
            else
            begin
                want = expected_ranges.pop_front();
                if (res_data.range_valid !== want.range_valid)
                    note_mismatch("range_valid", want.range_valid, res_data.range_valid);
                if (res_data.range_first !== want.range_first)
                    note_mismatch("range_first", want.range_first, res_data.range_first);
                if (res_data.first_present !== want.first_present)
                    note_mismatch("first_present", want.first_present, res_data.first_present);
                if (res_data.range_last !== want.range_last)
                    note_mismatch("range_last", want.range_last, res_data.range_last);
                if (res_data.last_present !== want.last_present)
                    note_mismatch("last_present", want.last_present, res_data.last_present);
                if (res_data.done_res !== want.done_res)
                    note_mismatch("done_res", want.done_res, res_data.done_res);
                if (res_data.status !== want.status)
                    note_mismatch("status", want.status, res_data.status);
            end
        end
    end

    // Result backpressure: random stall bursts of random length, none once
    // idling is switched off.
    always @(negedge clk)
    begin
        if (!idle_on)
            res_ready <= 1'b1;
        else if (rx_stall > 0)
        begin
            rx_stall--;
            res_ready <= 1'b0;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            rx_stall = $urandom_range(1, 18) - 1;
            res_ready <= 1'b0;
        end
        else
            res_ready <= 1'b1;
    end

    // -----------------------------------------------------------------------
    // Request side
    // -----------------------------------------------------------------------
    // Drive one request at the falling edge, hold it until accepted, then
    // predict its result. Valid stays high into the next request unless a
    // gap is chosen, so it is never dropped and raised in one step.
    task automatic send_byte(input logic [7:0] c, input logic mark);
        hbr_pkg::byte_t item;
        hbr_pkg::res_t  r;
        int             gap;
        item.ch       = c;
        item.end_mark = mark;
        gap = (idle_on && $urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= item;
        do @(posedge clk); while (!byte_ready);
        live_items++;
        if (predict_range(item, r))
            expected_ranges.insert(expected_ranges.size(), r);
    endtask

    // Append one byte to the staged header.
    task automatic stage_byte(input logic [7:0] c);
        hdr_bytes.insert(hdr_bytes.size(), c);
    endtask

    task automatic load_text(input string s);
        for (int i = 0; i < s.len(); i++)
            stage_byte(s[i]);
    endtask

    // Send the staged header bytes, then an end marker with a random byte.
    task automatic send_header_bytes();
        foreach (hdr_bytes[i])
            send_byte(hdr_bytes[i], 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        hdr_bytes.delete();
    endtask

    task automatic send_header(input string s);
        load_text(s);
        send_header_bytes();
    endtask

    // Hold the sender until every predicted result has come back.
    task automatic wait_for_results();
        @(negedge clk) byte_valid <= 1'b0;
        while (expected_ranges.size() != 0)
            @(posedge clk);
    endtask

    // Mostly short offsets, some near and past the width limit, a few very
    // long digit strings, now and then with leading zeros.
    function automatic string random_offset();
        logic [63:0] v;
        string       s;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom_range(0, 999);
            4, 5:       v = {$urandom, $urandom} & OFFSET_MAX;
            6:          v = OFFSET_MAX - $urandom_range(0, 3);
            7:          v = OFFSET_MAX + 64'd1 + $urandom_range(0, 9);
            8:          v = {$urandom, $urandom};
            default:    v = $urandom_range(0, 99);
        endcase
        s = $sformatf("%0d", v);
        if ($urandom_range(0, 9) == 0)
            s = {"000", s};
        return s;
    endfunction

    task automatic corrupt_header();
        int pos;
        pos = $urandom_range(0, hdr_bytes.size() - 1);
        case ($urandom_range(0, 4))
            0: hdr_bytes[pos] = 8'($urandom_range(0, 255));
            1: while (hdr_bytes.size() > pos) void'(hdr_bytes.pop_back());
            2: hdr_bytes.insert(pos, 8'($urandom_range(0, 255)));
            3: stage_byte(hbr_pkg::CH_COMMA);
            default:
            begin
                // pure noise
                hdr_bytes.delete();
                repeat ($urandom_range(1, 12))
                    stage_byte(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // Well-formed header with random prefix case and 1 to 4 specs; one in
    // four is then broken.
    task automatic build_random_header();
        logic [7:0] c;
        int         n_specs;
        for (int i = 0; i < 6; i++)
        begin
            c = PREFIX_TEXT[8*(5-i) +: 8];
            if (c != "=" && $urandom_range(0, 3) == 0)
                c = c - hbr_pkg::CASE_SHIFT;
            stage_byte(c);
        end
        n_specs = $urandom_range(1, 4);
        for (int k = 0; k < n_specs; k++)
        begin
            if (k > 0)
                stage_byte(hbr_pkg::CH_COMMA);
            case ($urandom_range(0, 2))
                0:       load_text({random_offset(), "-", random_offset()});
                1:       load_text({random_offset(), "-"});
                default: load_text({"-", random_offset()});
            endcase
        end
        if ($urandom_range(0, 3) == 0)
            corrupt_header();
    endtask

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------
    task automatic test_prefix_handling();
        send_header("BYTES=0-0");     // upper case prefix
        send_header("ByTeS=5-9");
        send_header("byt");           // prefix cut short
        send_header("");              // bare end marker
        send_header("bytez=1-2");     // wrong prefix, rest ignored
    endtask

    task automatic test_spec_forms();
        send_header("bytes=0-499,500-999,-500,9500-");
        send_header("bytes=7-");
        send_header("bytes=-1");
        send_header("bytes=");        // no spec at all
        send_header("bytes=1-2,");    // empty spec after a comma
    endtask

    task automatic test_offset_limits();
        send_header("bytes=0-281474976710655");
        send_header("bytes=281474976710655-");
        send_header("bytes=281474976710656-1");
        send_header("bytes=-2814749767106550");
        send_header("bytes=0000000000000000000001-2");
    endtask

    task automatic test_malformed();
        send_header("bytes=5-x");               // stray byte after an open range
        send_header("bytes=1-2,3-4x5-6,7-8");   // 1-2 stays emitted
        send_header("bytes=--1");
        send_header("bytes=1,2");
        send_header("bytes=-");
        load_text("bytes=1-");
        stage_byte(8'hFF);
        send_header_bytes();
        load_text("bytes=-");
        stage_byte(8'h00);
        send_header_bytes();
        load_text("bytes=1");
        stage_byte(hbr_pkg::CH_DASH | 8'h80);   // dash with the top bit set
        load_text("2");
        send_header_bytes();
    endtask

    task automatic test_random_headers();
        while (live_items < RANDOM_ITEMS)
        begin
            build_random_header();
            send_header_bytes();
        end
    endtask

    // Full rate on both sides for the tail of the run.
    task automatic test_back_to_back();
        idle_on = 1'b0;
        while (live_items < ITEM_TARGET)
        begin
            build_random_header();
            send_header_bytes();
        end
    endtask

    // -----------------------------------------------------------------------
    // Sequence
    // -----------------------------------------------------------------------
    initial
    begin
        byte_valid = 1'b0;
        byte_data  = '0;
        rst_n      = 1'b0;
        clear_parse_state();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
        idle_on = 1'b1;

        test_prefix_handling();
        test_spec_forms();
        test_offset_limits();
        test_malformed();
        wait_for_results();
        test_random_headers();
        wait_for_results();
        test_back_to_back();

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_ranges.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Hard stop in case the result stream hangs.
    initial
    begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> http_byte_range_parser.f
+incdir+src
src/hbr_pkg.sv
src/http_byte_range_parser.sv
src/hbr_checker.sv
tb/tb_http_byte_range_parser.sv
